// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Request codes, status codes, initial hash values and round constants.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_TOO_LONG     = 2'd1;
  localparam logic [1:0] ST_AFTER_FINISH = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // One queued item between the front and back parts.
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
  } item_t;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    begin
      unique case (idx)
        3'd0: v = 32'h67452301;
        3'd1: v = 32'hEFCDAB89;
        3'd2: v = 32'h98BADCFE;
        3'd3: v = 32'h10325476;
        default: v = 32'hC3D2E1F0;
      endcase
      return v;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] v;
    begin
      if (rnd < 7'd20) v = 32'h5A827999;
      else if (rnd < 7'd40) v = 32'h6ED9EBA1;
      else if (rnd < 7'd60) v = 32'h8F1BBCDC;
      else v = 32'hCA62C1D6;
      return v;
    end
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] v;
    begin
      if (rnd < 7'd20) v = (b & c) | (~b & d);
      else if (rnd >= 7'd40 && rnd < 7'd60) v = (b & c) | (b & d) | (c & d);
      else v = b ^ c ^ d;
      return v;
    end
  endfunction

endpackage

// ===== rtl/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Top level: request queue in front of the compression core.
// ----------------------------------------------------------------------------
// A byte item is registered in the two-entry queue before the core takes it,
// so bytes within a block pass at one per cycle; every 64th byte starts a
// compression (block reads from the byte RAM, 80 rounds and a final add),
// during which further items wait in the queue and the input stalls once two
// are held. A finish writes one pad byte per cycle up to the block end and
// compresses, once or twice, then gives five digest items (a repeated finish
// gives them again), or a single status item when an error is pending.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  message_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic [1:0]  status,
  output logic        last_word
);
  import sha1_pkg::*;

  logic  q_valid;
  logic  q_take;
  item_t q_item;

  sha1_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .message_byte,
    .q_valid, .q_item, .q_take
  );

  sha1_core u_core (
    .clk, .rst, .q_valid, .q_item, .q_take, .out_valid, .out_stall,
    .digest_word, .word_index, .status, .last_word
  );
endmodule

// ===== rtl/sha1_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts request items and places them in a two-entry queue for the core.
// ----------------------------------------------------------------------------
module sha1_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     req_type,
  input  logic [7:0]     message_byte,
  output logic           q_valid,
  output sha1_pkg::item_t q_item,
  input  logic           q_take
);
  import sha1_pkg::*;

  item_t      slot [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;

  // Unused request codes are dropped here and never reach the core.
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall && (req_type != REQ_UNUSED);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign pop      = q_valid && q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{req: req_type, data: message_byte};
    end
  end
endmodule

// ===== rtl/sha1_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sha1_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sha1_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 core
// Executes queued items: block fill, padding, 80-round compression, output.
// ----------------------------------------------------------------------------
module sha1_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sha1_pkg::item_t q_item,
  output logic            q_take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     digest_word,
  output logic [2:0]      word_index,
  output logic [1:0]      status,
  output logic            last_word
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_PAD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [31:0] h [5];
  logic [6:0]  fill;
  logic [63:0] bit_len;
  logic        ready;
  logic [1:0]  err;
  logic        finishing;
  logic        last_block;
  logic        pad_mark;
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [16];
  logic [6:0]  cnt;
  logic [2:0]  oidx;

  logic        we;
  logic [5:0]  waddr;
  logic [7:0]  wdata;
  logic [7:0]  rdata;
  logic [5:0]  ld_idx;
  logic [63:0] len_next;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] t;

  sha1_ram #(.Width(8), .Depth(64)) u_blk (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(cnt[5:0]), .rdata(rdata)
  );

  assign len_next = bit_len + 64'd8;
  assign q_take   = (state == S_IDLE) && q_valid;
  assign ld_idx   = cnt[5:0] - 6'd1;

  // Byte writes come from the item in idle, otherwise from the padding pass.
  always_comb begin
    we    = 1'b0;
    waddr = fill[5:0];
    wdata = q_item.data;
    if (state == S_IDLE) begin
      we = q_valid && (q_item.req == REQ_BYTE) && !ready && (err == ST_OK);
    end else if (state == S_PAD) begin
      we = 1'b1;
      if (pad_mark) begin
        wdata = PAD_BYTE;
      end else if (last_block && fill[5:0] >= 6'd56) begin
        wdata = bit_len[6'd63 - {fill[2:0], 3'b000} -: 8];
      end else begin
        wdata = 8'd0;
      end
    end
  end

  // Message schedule and round datapath; w[0] always holds the current word.
  assign w_mix = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign w_cur = w[0];
  assign t = {a[26:0], a[31:27]} + round_f(cnt, b, c, d) + e + w_cur + round_k(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= 7'd0;
      bit_len   <= 64'd0;
      ready     <= 1'b0;
      err       <= ST_OK;
      out_valid <= 1'b0;
      cnt       <= 7'd0;
      oidx      <= 3'd0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= init_hash(3'(i));
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_item.req)
              REQ_START: begin
                for (int i = 0; i < 5; i++) begin
                  h[i] <= init_hash(3'(i));
                end
                fill    <= 7'd0;
                bit_len <= 64'd0;
                ready   <= 1'b0;
                err     <= ST_OK;
              end
              REQ_BYTE: begin
                if (ready) begin
                  err <= ST_AFTER_FINISH;
                end else if (err == ST_OK) begin
                  bit_len <= len_next;
                  if (len_next == 64'd0) err <= ST_TOO_LONG;
                  if (fill[5:0] == 6'd63) begin
                    fill       <= 7'd0;
                    finishing  <= 1'b0;
                    cnt        <= 7'd0;
                    state      <= S_LOAD;
                  end else begin
                    fill <= fill + 7'd1;
                  end
                end
              end
              REQ_FINISH: begin
                oidx <= 3'd0;
                if (err != ST_OK) begin
                  out_valid   <= 1'b1;
                  digest_word <= 32'd0;
                  word_index  <= 3'd0;
                  status      <= err;
                  last_word   <= 1'b1;
                  state       <= S_OUT;
                end else if (ready) begin
                  state <= S_OUT;
                end else begin
                  // The length fits after the marker only below byte 56.
                  finishing  <= 1'b1;
                  last_block <= (fill[5:0] < 6'd56);
                  pad_mark   <= 1'b1;
                  state      <= S_PAD;
                end
              end
              default: ;
            endcase
          end
        end
        // Write one pad byte per cycle from the fill point to the block end.
        S_PAD: begin
          pad_mark <= 1'b0;
          if (fill[5:0] == 6'd63) begin
            fill  <= 7'd0;
            cnt   <= 7'd0;
            state <= S_LOAD;
          end else begin
            fill <= fill + 7'd1;
          end
        end
        // Read the block bytes in order; each read's data lands in the next cycle.
        S_LOAD: begin
          if (cnt == 7'd0) begin
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end else begin
            w[ld_idx[5:2]] <= {w[ld_idx[5:2]][23:0], rdata};
          end
          if (cnt == 7'd64) begin
            cnt   <= 7'd0;
            state <= S_RND;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        // One round per cycle; the schedule window shifts down each round.
        S_RND: begin
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_new;
          if (cnt == 7'd79) state <= S_ADD;
          cnt <= cnt + 7'd1;
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          cnt <= 7'd0;
          if (!finishing) begin
            state <= S_IDLE;
          end else if (last_block) begin
            bit_len <= 64'd0;
            ready   <= 1'b1;
            oidx    <= 3'd0;
            state   <= S_OUT;
          end else begin
            last_block <= 1'b1;
            state      <= S_PAD;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            if (out_valid && last_word) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_valid   <= 1'b1;
              digest_word <= h[oidx];
              word_index  <= oidx;
              status      <= ST_OK;
              last_word   <= (oidx == 3'd4);
              oidx        <= oidx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/sha1_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-1 port checker
// Checks result ordering and payload stability on the top-level ports.
// ----------------------------------------------------------------------------
module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic [1:0]  status,
  input logic        last_word
);
  import sha1_pkg::*;

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word))
    else $error("result changed while stalled");

  // The last item of a digest carries index four.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word && status == ST_OK |-> word_index == 3'd4)
    else $error("last item not at index four");

  // An error item is a single zero item.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_word && digest_word == 32'd0)
    else $error("malformed error item");
endmodule

bind sha1_stream_hasher sha1_checker u_chk (.*);
